[sv/assert_macros.svh]
// assertion macros shared by the list store rtl
// no dependencies; included by files that carry concurrent checks
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// check sampled on the clock, switched off while reset is asserted
`define ASSERT_CLK_RST(lbl, clk, rst_n, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// check sampled on the clock, also live during reset
`define ASSERT_CLK(lbl, clk, prop, msg) \
	lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

[sv/ial_pkg.sv]
// shared types and constants for the indexed list store
// used by ial_ctrl, ial_datapath and indexed_array_list
package ial_pkg;

	localparam int CAPACITY_DEF      = 256;
	localparam int ELEMENT_WIDTH_DEF = 32;

	localparam int POS_W   = 9;
	localparam int VALUE_W = 32;
	localparam int COUNT_W = 9;

	localparam logic [1:0] OP_APPEND = 2'd0;
	localparam logic [1:0] OP_POP    = 2'd1;
	localparam logic [1:0] OP_INSERT = 2'd2;
	localparam logic [1:0] OP_REMOVE = 2'd3;

	typedef struct packed {
		logic load;
		logic decide;
		logic step;
		logic finish;
	} ial_cmd_t;

	typedef struct packed {
		logic rem_zero;
		logic out_free;
	} ial_status_t;

endpackage

[sv/indexed_array_list.sv]
// indexed_array_list: fixed-capacity ordered list with append, pop, insert and remove.
// An item is taken only while the block is idle; it runs through the decide, shift and
// finish states. The shift loop through the entry memory reads n entries, where
// n = count - position for insert and remove (pop reads one entry, append and refused
// requests none), one read and one write a cycle, moving one entry per cycle. The next
// item may be accepted in the cycle after the result is registered. A finished
// result waits in the output register until taken; while it waits the next item is
// accepted and runs up to its own result. Refused requests leave the store unchanged
// and report ok = 0, element_out = 0 and the unchanged count.
// depends on ial_pkg, ial_ctrl, ial_datapath and assert_macros.svh
`include "assert_macros.svh"

module indexed_array_list #(
	parameter int CAPACITY      = ial_pkg::CAPACITY_DEF,
	parameter int ELEMENT_WIDTH = ial_pkg::ELEMENT_WIDTH_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        in_valid,
	output logic                        in_stall,
	input  logic [1:0]                  operation,
	input  logic [ial_pkg::POS_W-1:0]   position,
	input  logic [ial_pkg::VALUE_W-1:0] value,
	output logic                        out_valid,
	input  logic                        out_stall,
	output logic                        ok,
	output logic [ial_pkg::VALUE_W-1:0] element_out,
	output logic [ial_pkg::COUNT_W-1:0] count
);
	import ial_pkg::*;

	ial_cmd_t    cmd;
	ial_status_t status;

	ial_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.status   (status),
		.cmd      (cmd)
	);

	ial_datapath #(
		.CAPACITY      (CAPACITY),
		.ELEMENT_WIDTH (ELEMENT_WIDTH)
	) u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.status      (status),
		.operation   (operation),
		.position    (position),
		.value       (value),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.ok          (ok),
		.element_out (element_out),
		.count       (count)
	);

	// an accepted item keeps the input side closed while it is worked on
	`ASSERT_CLK_RST(a_busy_after_accept, clk, arst_n, (in_valid && !in_stall) |=> in_stall, "input open right after an accept")

	// a refused request never hands back an element
	`ASSERT_CLK_RST(a_refused_zero, clk, arst_n, (out_valid && !ok) |-> (element_out == '0), "refused result carries an element")

	// the reported count stays within capacity
	`ASSERT_CLK_RST(a_count_cap, clk, arst_n, out_valid |-> (32'(count) <= CAPACITY), "count beyond capacity")

	// the sequencer only works on an item that was taken while idle
	`ASSERT_CLK(a_idle_no_cmd, clk, (!in_stall) |-> (!cmd.decide && !cmd.step && !cmd.finish), "datapath command while idle")

endmodule

[sv/ial_ctrl.sv]
// sequencer for the list store: takes an item, runs the shift, hands off the result
// depends on ial_pkg for the command and status structs
module ial_ctrl (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_stall,
	input  ial_pkg::ial_status_t status,
	output ial_pkg::ial_cmd_t    cmd
);
	import ial_pkg::*;

	localparam logic [1:0] ST_IDLE   = 2'd0;
	localparam logic [1:0] ST_DECIDE = 2'd1;
	localparam logic [1:0] ST_RUN    = 2'd2;
	localparam logic [1:0] ST_FIN    = 2'd3;

	logic [1:0] state_q;
	logic [1:0] state_d;

	always_comb begin
		state_d = state_q;
		cmd     = '0;
		unique case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					cmd.load = 1'b1;
					state_d  = ST_DECIDE;
				end
			end
			ST_DECIDE: begin
				cmd.decide = 1'b1;
				state_d    = ST_RUN;
			end
			ST_RUN: begin
				// the cycle with nothing left to read retires the last pending write
				if (!status.rem_zero) begin
					cmd.step = 1'b1;
				end else begin
					state_d = ST_FIN;
				end
			end
			ST_FIN: begin
				if (status.out_free) begin
					cmd.finish = 1'b1;
					state_d    = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	assign in_stall = (state_q != ST_IDLE);

endmodule

[sv/ial_datapath.sv]
// list store datapath: entry memory, length, shift pointers and result register
// depends on ial_pkg; driven by ial_ctrl commands
module ial_datapath #(
	parameter int CAPACITY      = ial_pkg::CAPACITY_DEF,
	parameter int ELEMENT_WIDTH = ial_pkg::ELEMENT_WIDTH_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  ial_pkg::ial_cmd_t           cmd,
	output ial_pkg::ial_status_t        status,
	input  logic [1:0]                  operation,
	input  logic [ial_pkg::POS_W-1:0]   position,
	input  logic [ial_pkg::VALUE_W-1:0] value,
	output logic                        out_valid,
	input  logic                        out_stall,
	output logic                        ok,
	output logic [ial_pkg::VALUE_W-1:0] element_out,
	output logic [ial_pkg::COUNT_W-1:0] count
);
	import ial_pkg::*;

	localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
	localparam int LW = $clog2(CAPACITY + 1);
	localparam int CW = (LW > POS_W) ? LW : POS_W;

	logic [ELEMENT_WIDTH-1:0] mem [CAPACITY];
	logic [ELEMENT_WIDTH-1:0] rdata_q;

	logic [1:0]               op_q;
	logic [POS_W-1:0]         pos_q;
	logic [ELEMENT_WIDTH-1:0] val_q;
	logic [LW-1:0]            len_q;
	logic [AW-1:0]            at_q;
	logic [AW-1:0]            ra_q;
	logic [LW-1:0]            rem_q;
	logic                     first_q;
	logic                     grow_q;
	logic                     okd_q;
	logic [ELEMENT_WIDTH-1:0] taken_q;

	logic                     rv_s1;
	logic                     first_s1;
	logic [AW-1:0]            wa_s1;

	logic                     res_ok_q;
	logic [VALUE_W-1:0]       res_elem_q;
	logic [COUNT_W-1:0]       res_count_q;
	logic                     out_valid_q;

	// request decode
	logic [CW-1:0] lenx;
	logic [CW-1:0] posx;
	logic [CW-1:0] atx;
	logic [CW-1:0] nx;
	logic [CW-1:0] rax;
	logic          not_full;
	logic          ok_d;
	logic          grow_d;

	always_comb begin
		lenx     = CW'(len_q);
		posx     = CW'(pos_q);
		not_full = lenx < CW'(CAPACITY);
		ok_d     = 1'b0;
		grow_d   = 1'b0;
		atx      = posx;
		case (op_q)
			OP_APPEND: begin
				ok_d   = not_full;
				grow_d = 1'b1;
				atx    = lenx;
			end
			OP_POP: begin
				ok_d = (lenx != '0);
				atx  = lenx - CW'(1);
			end
			OP_INSERT: begin
				ok_d   = (posx <= lenx) && not_full;
				grow_d = 1'b1;
			end
			default: begin
				ok_d = (posx < lenx);
			end
		endcase
		nx  = ok_d ? (lenx - atx) : '0;
		// insert walks down from the tail, remove walks up from the position
		rax = grow_d ? (lenx - CW'(1)) : atx;
	end

	// memory ports
	logic                     we;
	logic [AW-1:0]            wa;
	logic [ELEMENT_WIDTH-1:0] wd;

	assign we = (rv_s1 && !first_s1) || (cmd.finish && okd_q && grow_q);
	assign wa = rv_s1 ? wa_s1 : at_q;
	assign wd = rv_s1 ? rdata_q : val_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[wa] <= wd;
		end
		if (cmd.step) begin
			rdata_q <= mem[ra_q];
		end
	end

	logic [63:0] val64;
	assign val64 = 64'(value);

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			op_q  <= operation;
			pos_q <= position;
			val_q <= val64[ELEMENT_WIDTH-1:0];
		end
		if (cmd.decide) begin
			at_q    <= atx[AW-1:0];
			ra_q    <= rax[AW-1:0];
			grow_q  <= grow_d;
			okd_q   <= ok_d;
			first_q <= 1'b1;
		end else if (cmd.step) begin
			ra_q    <= grow_q ? (ra_q - AW'(1)) : (ra_q + AW'(1));
			first_q <= 1'b0;
		end
		if (cmd.step) begin
			wa_s1    <= grow_q ? (ra_q + AW'(1)) : (ra_q - AW'(1));
			first_s1 <= first_q && !grow_q;
		end
		// the first read of a remove is the element handed back
		if (rv_s1 && first_s1) begin
			taken_q <= rdata_q;
		end
	end

	logic [LW-1:0] len_next;
	logic [31:0]   len32;
	logic [63:0]   taken64;

	assign len_next = !okd_q ? len_q : (grow_q ? (len_q + LW'(1)) : (len_q - LW'(1)));
	assign len32    = 32'(len_next);
	assign taken64  = 64'(taken_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			len_q       <= '0;
			rem_q       <= '0;
			rv_s1       <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.decide) begin
				rem_q <= nx[LW-1:0];
			end else if (cmd.step) begin
				rem_q <= rem_q - LW'(1);
			end
			rv_s1 <= cmd.step;
			if (cmd.finish) begin
				len_q       <= len_next;
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.finish) begin
			res_ok_q    <= okd_q;
			res_elem_q  <= (okd_q && !grow_q) ? taken64[VALUE_W-1:0] : '0;
			res_count_q <= len32[COUNT_W-1:0];
		end
	end

	assign status.rem_zero = (rem_q == '0);
	assign status.out_free = !out_valid_q || !out_stall;

	assign out_valid   = out_valid_q;
	assign ok          = res_ok_q;
	assign element_out = res_elem_q;
	assign count       = res_count_q;

endmodule

[verif/indexed_array_list_tb.sv]
// self-checking testbench for indexed_array_list: list requests, refusals and a full store
// depends on ial_pkg and the indexed_array_list rtl
`timescale 1ns / 1ps

module indexed_array_list_tb;
	import ial_pkg::*;

	localparam int LIST_CAP      = CAPACITY_DEF;
	localparam int RANDOM_ITEMS  = 1950;
	localparam int LONG_HOLD     = 800;
	localparam int DRAIN_CYCLES  = 300;

	typedef struct {
		logic [1:0]         op;
		logic [POS_W-1:0]   pos;
		logic [VALUE_W-1:0] val;
		int                 gap;
	} list_request_t;

	typedef struct packed {
		logic               ok;
		logic [VALUE_W-1:0] elem;
		logic [COUNT_W-1:0] cnt;
	} list_answer_t;

	logic               clk = 1'b0;
	logic               arst_n = 1'b0;
	logic               in_valid = 1'b0;
	logic               in_stall;
	logic [1:0]         operation = OP_APPEND;
	logic [POS_W-1:0]   position = '0;
	logic [VALUE_W-1:0] value = '0;
	logic               out_valid;
	logic               out_stall = 1'b0;
	logic               ok;
	logic [VALUE_W-1:0] element_out;
	logic [COUNT_W-1:0] count;

	// pending requests, fed by the stimulus block
	list_request_t pending[$];
	list_request_t drive_req;
	int            send_wait = 0;
	int            gen_len = 0;
	bit            quiet_sender = 0;

	// list contents as the block should hold them
	logic [VALUE_W-1:0] shadow_list [LIST_CAP];
	int                 shadow_len = 0;
	list_answer_t       answers_due[$];
	list_answer_t       due;

	int hold_left = 0;
	int hold_draw;
	int take_count = 0;

	int mismatches = 0;
	int ops_taken[4] = '{0, 0, 0, 0};
	int refused = 0;
	int full_hits = 0;
	int peak_len = 0;
	int checked = 0;

	indexed_array_list DUT (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.operation  (operation),
		.position   (position),
		.value      (value),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.ok         (ok),
		.element_out(element_out),
		.count      (count)
	);

	always #5 clk = ~clk;

	function automatic list_answer_t apply_list_request(logic [1:0] op, logic [POS_W-1:0] pos,
			logic [VALUE_W-1:0] val);
		list_answer_t ans;
		int at;
		ans = '0;
		case (op)
		OP_APPEND, OP_INSERT: begin
			at = (op == OP_APPEND) ? shadow_len : int'(pos);
			if (at <= shadow_len && shadow_len < LIST_CAP) begin
				for (int k = shadow_len; k > at; k--)
					shadow_list[k] = shadow_list[k - 1];
				shadow_list[at] = val;
				shadow_len++;
				ans.ok = 1'b1;
			end
		end
		default: begin
			at = (op == OP_POP) ? shadow_len - 1 : int'(pos);
			if (shadow_len > 0 && at < shadow_len) begin
				ans.elem = shadow_list[at];
				for (int k = at; k + 1 < shadow_len; k++)
					shadow_list[k] = shadow_list[k + 1];
				shadow_len--;
				ans.ok = 1'b1;
			end
		end
		endcase
		ans.cnt = shadow_len[COUNT_W-1:0];
		return ans;
	endfunction

	// stimulus side keeps only the length, to aim positions
	task automatic queue_request(logic [1:0] op, int pos, logic [VALUE_W-1:0] val);
		list_request_t r;
		r.op = op;
		r.pos = pos[POS_W-1:0];
		r.val = val;
		r.gap = quiet_sender ? 0 : $urandom_range(0, 9);
		pending.push_back(r);
		case (op)
		OP_APPEND: if (gen_len < LIST_CAP) gen_len++;
		OP_INSERT: if (pos <= gen_len && gen_len < LIST_CAP) gen_len++;
		OP_POP:    if (gen_len > 0) gen_len--;
		default:   if (pos < gen_len) gen_len--;
		endcase
	endtask

	task automatic add_random_request(int grow_pct);
		int roll;
		int pos;
		int reach;
		logic [1:0] op;
		roll = $urandom_range(0, 99);
		if ($urandom_range(0, 99) < grow_pct)
			op = $urandom_range(0, 1) ? OP_INSERT : OP_APPEND;
		else
			op = $urandom_range(0, 1) ? OP_REMOVE : OP_POP;
		pos = $urandom_range(0, LIST_CAP);
		if (op == OP_INSERT) begin
			reach = (gen_len < 8) ? gen_len : 8;
			if (roll < 10)
				pos = (gen_len < LIST_CAP) ? $urandom_range(gen_len + 1, LIST_CAP) : pos;
			else if (roll < 25)
				pos = $urandom_range(0, gen_len);
			else
				pos = gen_len - $urandom_range(0, reach);
		end else if (op == OP_REMOVE && gen_len > 0) begin
			reach = (gen_len - 1 < 8) ? gen_len - 1 : 8;
			if (roll < 10)
				pos = $urandom_range(gen_len, LIST_CAP);
			else if (roll < 25)
				pos = $urandom_range(0, gen_len - 1);
			else
				pos = gen_len - 1 - $urandom_range(0, reach);
		end
		queue_request(op, pos, $urandom);
	endtask

	// driver: payload only moves when the channel is free
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
			operation <= OP_APPEND;
			position <= '0;
			value <= '0;
			send_wait <= 0;
		end else if (!in_valid || !in_stall) begin
			if (send_wait > 0) begin
				in_valid <= 1'b0;
				send_wait <= send_wait - 1;
			end else if (pending.size() != 0) begin
				drive_req = pending.pop_front();
				operation <= drive_req.op;
				position <= drive_req.pos;
				value <= drive_req.val;
				in_valid <= 1'b1;
				send_wait <= drive_req.gap;
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	// receiver: stall stretch drawn after each result, two long holds to back the block up
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_stall <= 1'b0;
			hold_left <= 0;
			take_count <= 0;
		end else if (out_valid && !out_stall) begin
			if (take_count == 400 || take_count == 1400)
				hold_draw = LONG_HOLD;
			else if ((take_count / 80) % 3 == 1)
				hold_draw = 0;
			else
				hold_draw = $urandom_range(0, 9);
			hold_left <= hold_draw;
			out_stall <= (hold_draw != 0);
			take_count <= take_count + 1;
		end else if (hold_left != 0) begin
			hold_left <= hold_left - 1;
			out_stall <= (hold_left > 1);
		end
	end

	// monitor: predict on accepted items, check accepted results
	always @(posedge clk) begin
		if (arst_n) begin
			if (in_valid && !in_stall) begin
				if (shadow_len == LIST_CAP)
					full_hits++;
				ops_taken[operation]++;
				answers_due.push_back(apply_list_request(operation, position, value));
				if (shadow_len > peak_len)
					peak_len = shadow_len;
			end
			if (out_valid && !out_stall) begin
				if (answers_due.size() == 0) begin
					$display("%0t: result with nothing expected: ok %0d element %h count %0d",
						$time, ok, element_out, count);
					mismatches++;
				end else begin
					due = answers_due.pop_front();
					checked++;
					if (!due.ok)
						refused++;
					if (ok !== due.ok) begin
						$display("%0t: ok expected %0d actual %0d", $time, due.ok, ok);
						mismatches++;
					end
					if (element_out !== due.elem) begin
						$display("%0t: element_out expected %h actual %h", $time, due.elem,
							element_out);
						mismatches++;
					end
					if (count !== due.cnt) begin
						$display("%0t: count expected %0d actual %0d", $time, due.cnt, count);
						mismatches++;
					end
				end
			end
		end
	end

	initial begin
		int n_rand;
		int mode;
		int linger;
		int steps;
		int grow_pct;
		n_rand = 0;
		mode = 2;

		// refusals on an empty list, then front, middle and end edits
		queue_request(OP_POP, 0, 32'h0000_0000);
		queue_request(OP_REMOVE, 0, 32'h0000_0000);
		queue_request(OP_INSERT, 1, 32'hDEAD_BEEF);
		queue_request(OP_APPEND, 0, 32'h0000_0000);
		queue_request(OP_APPEND, 511, 32'hFFFF_FFFF);
		queue_request(OP_INSERT, 0, 32'hA5A5_A5A5);
		queue_request(OP_INSERT, 3, 32'h5A5A_5A5A);
		queue_request(OP_INSERT, 5, 32'h1111_1111);
		queue_request(OP_INSERT, 2, 32'h1234_5678);
		queue_request(OP_REMOVE, 5, 32'h0000_0000);
		queue_request(OP_REMOVE, 256, 32'h0000_0000);
		queue_request(OP_INSERT, 256, 32'h8765_4321);
		queue_request(OP_REMOVE, 0, 32'h0000_0000);
		queue_request(OP_REMOVE, 2, 32'h0000_0000);
		queue_request(OP_POP, 256, 32'hFFFF_FFFF);
		queue_request(OP_REMOVE, 1, 32'h0000_0000);
		queue_request(OP_POP, 0, 32'h0000_0000);
		queue_request(OP_POP, 0, 32'h0000_0000);
		queue_request(OP_APPEND, 0, 32'h8000_0000);
		queue_request(OP_APPEND, 0, 32'h0000_0001);

		// phases: grow to full and linger, mixed, shrink to empty and linger
		while (n_rand < RANDOM_ITEMS) begin
			mode = (mode + 1) % 3;
			grow_pct = (mode == 0) ? 80 : (mode == 1) ? 50 : 20;
			linger = 0;
			for (steps = 0; steps < 800 && n_rand < RANDOM_ITEMS; steps++) begin
				if (steps % 40 == 0)
					quiet_sender = ($urandom_range(0, 3) == 0);
				add_random_request(grow_pct);
				n_rand++;
				if ((mode == 0 && gen_len == LIST_CAP) || (mode == 2 && gen_len == 0))
					linger++;
				if ((mode == 0 && linger >= 30) || (mode == 2 && linger >= 15) ||
						(mode == 1 && steps >= 150))
					break;
			end
		end

		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		while (pending.size() != 0 || in_valid)
			@(posedge clk);
		while (answers_due.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (answers_due.size() != 0) begin
			$display("%0t: %0d expected results never arrived", $time, answers_due.size());
			mismatches += answers_due.size();
		end

		$display("requests taken: %0d append, %0d pop, %0d insert, %0d remove, %0d refused",
			ops_taken[OP_APPEND], ops_taken[OP_POP], ops_taken[OP_INSERT],
			ops_taken[OP_REMOVE], refused);
		$display("results checked %0d, longest list %0d, requests against a full list %0d",
			checked, peak_len, full_hits);
		if (mismatches == 0)
			$display("end of test: clean");
		else
			$display("end of test: mismatches");
		$finish;
	end

	initial begin
		#30_000_000;
		$display("timeout: %0d results still expected", answers_due.size());
		$display("end of test: mismatches");
		$finish;
	end

endmodule
